// ===== design/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// shared types, register indexes, mode codes and cordic constants
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd6;

    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;

    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int MAX_STAGES = 24;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic               in_last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               out_last;
    } out_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [23:0] scale_factor;
        logic [15:0]        rotation_angle;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
    } cfg_t;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic signed [32:0]     dx;
        logic signed [32:0]     dy;
        logic signed [31:0]     x0;
        logic signed [31:0]     y0;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [CW-1:0]   cz;
        logic                   flip;
    } pipe_t;

    function automatic logic signed [CW-1:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// ===== design/ppt_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// ppt_cordic_stage
// one registered cordic rotation step with the vertex carried alongside
// ----------------------------------------------------------------------------
module ppt_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ppt_pkg::pipe_t d,
    output ppt_pkg::pipe_t q
);

    ppt_pkg::pipe_t q_reg;
    ppt_pkg::pipe_t q_next;

    always_comb
    begin
        q_next = d;
        if (d.cz >= 0)
        begin
            q_next.cx = d.cx - (d.cy >>> SHIFT);
            q_next.cy = d.cy + (d.cx >>> SHIFT);
            q_next.cz = d.cz - ppt_pkg::atan_turn(SHIFT);
        end
        else
        begin
            q_next.cx = d.cx + (d.cy >>> SHIFT);
            q_next.cy = d.cy - (d.cx >>> SHIFT);
            q_next.cz = d.cz + ppt_pkg::atan_turn(SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== design/ppt_affine.sv =====
// ----------------------------------------------------------------------------
// ppt_affine
// trig rounding or scale select, product, round and saturate stages of the transform
// ----------------------------------------------------------------------------
module ppt_affine #(
    parameter int SAT_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ppt_pkg::cfg_t  cfg,
    input  ppt_pkg::pipe_t d,
    output logic           out_valid,
    output ppt_pkg::out_t  out_data
);

    localparam logic signed [42:0] SAT_HI = (43'sd1 <<< (SAT_W - 1)) - 43'sd1;
    localparam logic signed [42:0] SAT_LO = -SAT_HI - 43'sd1;

    // trig stage
    logic               t_v_reg;
    logic               t_last_reg;
    logic signed [32:0] t_dx_reg, t_dy_reg;
    logic signed [31:0] t_x0_reg, t_y0_reg;
    logic signed [26:0] t_c_reg, t_s_reg;
    logic signed [26:0] t_c_next, t_s_next;
    logic signed [34:0] xf, yf;

    // product stage
    logic               m_v_reg;
    logic               m_last_reg;
    logic signed [31:0] m_x0_reg, m_y0_reg;
    logic signed [59:0] m_dxc_reg, m_dys_reg, m_dxs_reg, m_dyc_reg;

    // round stage
    logic               s_v_reg;
    logic               s_last_reg;
    logic signed [41:0] s_px_reg, s_py_reg;
    logic signed [41:0] s_px_next, s_py_next;
    logic signed [60:0] sum_x, sum_y;

    // output stage
    logic               o_v_reg;
    ppt_pkg::out_t      o_data_reg;
    ppt_pkg::out_t      o_data_next;
    logic signed [42:0] fx, fy;

    always_comb
    begin
        xf = d.flip ? -35'(d.cx) : 35'(d.cx);
        yf = d.flip ? -35'(d.cy) : 35'(d.cy);
        xf = xf + 35'sd32;
        yf = yf + 35'sd32;
        if (cfg.mode == ppt_pkg::MODE_SCALE)
        begin
            t_c_next = 27'(cfg.scale_factor);
            t_s_next = '0;
        end
        else
        begin
            t_c_next = $signed(xf[32:6]);
            t_s_next = $signed(yf[32:6]);
        end
    end

    always_comb
    begin
        s_px_next = 42'(m_x0_reg);
        s_py_next = 42'(m_y0_reg);
        sum_x = '0;
        sum_y = '0;
        case (cfg.mode)
            ppt_pkg::MODE_TRANSLATE:
            begin
                s_px_next = 42'(m_x0_reg) + 42'(cfg.offset_x);
                s_py_next = 42'(m_y0_reg) + 42'(cfg.offset_y);
            end
            ppt_pkg::MODE_SCALE:
            begin
                sum_x = 61'(m_dxc_reg) + 61'sd32768;
                sum_y = 61'(m_dyc_reg) + 61'sd32768;
                s_px_next = $signed(sum_x[57:16]);
                s_py_next = $signed(sum_y[57:16]);
            end
            ppt_pkg::MODE_ROTATE:
            begin
                sum_x = 61'(m_dxc_reg) - 61'(m_dys_reg) + 61'sd8388608;
                sum_y = 61'(m_dxs_reg) + 61'(m_dyc_reg) + 61'sd8388608;
                s_px_next = 42'($signed(sum_x[60:24]));
                s_py_next = 42'($signed(sum_y[60:24]));
            end
            default:
            begin
                s_px_next = 42'(m_x0_reg);
                s_py_next = 42'(m_y0_reg);
            end
        endcase
    end

    always_comb
    begin
        if (cfg.mode == ppt_pkg::MODE_SCALE || cfg.mode == ppt_pkg::MODE_ROTATE)
        begin
            fx = 43'(s_px_reg) + 43'(cfg.center_x);
            fy = 43'(s_py_reg) + 43'(cfg.center_y);
        end
        else
        begin
            fx = 43'(s_px_reg);
            fy = 43'(s_py_reg);
        end
        if (fx > SAT_HI)
            fx = SAT_HI;
        else if (fx < SAT_LO)
            fx = SAT_LO;
        if (fy > SAT_HI)
            fy = SAT_HI;
        else if (fy < SAT_LO)
            fy = SAT_LO;
        o_data_next.out_x    = fx[31:0];
        o_data_next.out_y    = fy[31:0];
        o_data_next.out_last = s_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t_v_reg <= d.valid;
            m_v_reg <= t_v_reg;
            s_v_reg <= m_v_reg;
            o_v_reg <= s_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_last_reg <= d.last;
            t_dx_reg   <= d.dx;
            t_dy_reg   <= d.dy;
            t_x0_reg   <= d.x0;
            t_y0_reg   <= d.y0;
            t_c_reg    <= t_c_next;
            t_s_reg    <= t_s_next;

            m_last_reg <= t_last_reg;
            m_x0_reg   <= t_x0_reg;
            m_y0_reg   <= t_y0_reg;
            m_dxc_reg  <= t_dx_reg * t_c_reg;
            m_dys_reg  <= t_dy_reg * t_s_reg;
            m_dxs_reg  <= t_dx_reg * t_s_reg;
            m_dyc_reg  <= t_dy_reg * t_c_reg;

            s_last_reg <= m_last_reg;
            s_px_reg   <= s_px_next;
            s_py_reg   <= s_py_next;

            o_data_reg <= o_data_next;
        end
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_data_reg;

endmodule

// ===== design/planar_point_transform_top.sv =====
// ----------------------------------------------------------------------------
// planar_point_transform_top
// translate, scale or rotate a stream of polygon vertices
// ----------------------------------------------------------------------------
// vertices enter on in_valid/in_ready, results leave on out_valid/out_ready
// one transfer in gives exactly one transfer out, in order, last mark copied
// one vertex per cycle sustained while out_ready does not hold the pipeline;
// every stage is registered: an input stage, the cordic
// steps, then trig rounding, products, rounding and saturation
// the rotation sine and cosine are rebuilt for every vertex in the cordic
// chain, so the chain length sets the latency
// the cfg port writes one register per cycle with cfg_we; write it only
// while no vertex is in flight
// reset clears all pipeline valid bits and loads the register defaults
// when out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module planar_point_transform_top #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ppt_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ppt_pkg::out_t                      out_data,
    input  logic                               cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int RUN   = (CORDIC_STAGES < ppt_pkg::MAX_STAGES) ?
                           CORDIC_STAGES : ppt_pkg::MAX_STAGES;

    ppt_pkg::cfg_t  cfg_reg;
    ppt_pkg::pipe_t in_reg;
    ppt_pkg::pipe_t in_next;
    ppt_pkg::pipe_t pipe [0:RUN];
    logic           en;
    logic signed [ppt_pkg::CW-1:0] ang;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= ppt_pkg::MODE_TRANSLATE;
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
            cfg_reg.scale_factor   <= 24'sd65536;
            cfg_reg.rotation_angle <= '0;
            cfg_reg.center_x       <= '0;
            cfg_reg.center_y       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppt_pkg::REG_MODE:     cfg_reg.mode           <= cfg_wdata[1:0];
                ppt_pkg::REG_OFFSET_X: cfg_reg.offset_x       <= cfg_wdata;
                ppt_pkg::REG_OFFSET_Y: cfg_reg.offset_y       <= cfg_wdata;
                ppt_pkg::REG_SCALE:    cfg_reg.scale_factor   <= cfg_wdata[23:0];
                ppt_pkg::REG_ANGLE:    cfg_reg.rotation_angle <= cfg_wdata[15:0];
                ppt_pkg::REG_CENTER_X: cfg_reg.center_x       <= cfg_wdata;
                ppt_pkg::REG_CENTER_Y: cfg_reg.center_y       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // fold the angle into plus or minus a quarter turn
    always_comb
    begin
        ang           = ppt_pkg::CW'($signed({cfg_reg.rotation_angle, 16'h0000}));
        in_next.valid = in_valid;
        in_next.last  = in_data.in_last;
        in_next.x0    = in_data.in_x;
        in_next.y0    = in_data.in_y;
        in_next.dx    = 33'(in_data.in_x) - 33'(cfg_reg.center_x);
        in_next.dy    = 33'(in_data.in_y) - 33'(cfg_reg.center_y);
        in_next.cx    = ppt_pkg::CORDIC_GAIN;
        in_next.cy    = '0;
        in_next.cz    = ang;
        in_next.flip  = 1'b0;
        if (ang > 34'sh040000000)
        begin
            in_next.cz   = ang - 34'sh080000000;
            in_next.flip = 1'b1;
        end
        else if (ang < -34'sh040000000)
        begin
            in_next.cz   = ang + 34'sh080000000;
            in_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            in_reg <= in_next;
        end
    end

    assign pipe[0] = in_reg;

    for (genvar k = 0; k < RUN; k++)
    begin : g_cordic
        ppt_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (pipe[k]),
            .q     (pipe[k+1])
        );
    end

    ppt_affine #(
        .SAT_W (SAT_W)
    ) u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .d         (pipe[RUN]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
